### sv/sorted_key_value_table_core_assert.svh
// Assertion macros used by the checker of the sorted key/value table.
`ifndef SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SKVT_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SKVT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/skvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int FIELD_W    = 32;
  localparam int EW         = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = 4;
  localparam int OCC_W      = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    SKVT_IDLE,
    SKVT_APPLY
  } skvt_state_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rem_en;
  } skvt_cell_ctl_t;

  function automatic logic [CNT_W-1:0] ones(input logic [DEPTH-1:0] v);
    logic [CNT_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sum = sum + CNT_W'(v[i]);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

### sv/skvt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module skvt_cell
  import skvt_pkg::*;
(
  input  wire logic           clk,
  input  wire skvt_cell_ctl_t ctl,
  input  wire logic           occ,
  input  wire logic [EW-1:0]  cmp_key,
  input  wire logic [EW-1:0]  cmp_value,
  input  wire logic [EW-1:0]  ins_key,
  input  wire logic [EW-1:0]  ins_value,
  input  wire logic           left_lt,
  input  wire logic [EW-1:0]  left_key,
  input  wire logic [EW-1:0]  left_value,
  input  wire logic [EW-1:0]  right_key,
  input  wire logic [EW-1:0]  right_value,
  input  wire logic           seen_in,
  output logic      [EW-1:0]  key_o,
  output logic      [EW-1:0]  value_o,
  output logic                lt_o,
  output logic                match_o,
  output logic                seen_o
);

  logic [EW-1:0] key_r, key_nxt;
  logic [EW-1:0] value_r, value_nxt;
  logic          lt_r, lt_nxt;
  logic          match_r, match_nxt;
  logic          at_pos;

  always_comb begin
    seen_o    = seen_in | match_r;
    at_pos    = left_lt & ~lt_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    lt_nxt    = lt_r;
    match_nxt = match_r;
    if (ctl.cmp_en) begin
      lt_nxt    = occ && ($signed(key_r) < $signed(cmp_key));
      match_nxt = occ && (value_r == cmp_value);
    end
    if (ctl.ins_en) begin
      if (!lt_r) begin
        if (at_pos) begin
          key_nxt   = ins_key;
          value_nxt = ins_value;
        end else begin
          key_nxt   = left_key;
          value_nxt = left_value;
        end
      end
    end else if (ctl.rem_en && seen_o) begin
      key_nxt   = right_key;
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    lt_r    <= lt_nxt;
    match_r <= match_nxt;
  end

  assign key_o   = key_r;
  assign value_o = value_r;
  assign lt_o    = lt_r;
  assign match_o = match_r;

endmodule

`default_nettype wire

### sv/sorted_key_value_table_core.sv
// No new request is taken in the apply state or while a result beat is
// stalled; the cell row compares in the accept cycle and shifts or
// reports in the following apply cycle.
// Reset: synchronous active-low rst_n empties the table and drops any
// pending result; stored keys and values keep stale contents.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_value_table_core
  import skvt_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic        [1:0]        in_req_type,
  input  wire logic signed [FIELD_W-1:0] in_entry_key,
  input  wire logic signed [FIELD_W-1:0] in_entry_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic             [1:0]        out_status,
  output logic                          out_found,
  output logic             [POS_W-1:0]  out_position,
  output logic signed      [FIELD_W-1:0] out_found_key,
  output logic             [OCC_W-1:0]  out_match_count,
  output logic             [OCC_W-1:0]  out_occupancy
);

  skvt_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  req_t             req_r;
  logic [EW-1:0]    key_r;
  logic [EW-1:0]    value_r;
  skvt_cell_ctl_t   ctl;
  logic             accept;

  logic [EW-1:0]    cell_key   [DEPTH];
  logic [EW-1:0]    cell_value [DEPTH];
  logic [DEPTH-1:0] lt, match, seen, seen_in, occ;

  logic [CNT_W-1:0] ins_pos, first_pos, hits;
  logic             found, full, empty;
  logic [EW-1:0]    first_key;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic             out_found_r, out_found_nxt;
  logic [POS_W-1:0] out_position_r, out_position_nxt;
  logic [FIELD_W-1:0] out_found_key_r, out_found_key_nxt;
  logic [OCC_W-1:0] out_match_count_r, out_match_count_nxt;
  logic [OCC_W-1:0] out_occupancy_r, out_occupancy_nxt;

  assign in_stall = (state_r != SKVT_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          left_lt;
    logic [EW-1:0] left_key, left_value, right_key, right_value;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_key   = key_r;
      assign left_value = value_r;
      assign seen_in[i] = 1'b0;
    end else begin : g_mid
      assign left_lt    = lt[i-1];
      assign left_key   = cell_key[i-1];
      assign left_value = cell_value[i-1];
      assign seen_in[i] = seen[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key   = cell_key[i];
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_key   = cell_key[i+1];
      assign right_value = cell_value[i+1];
    end

    assign occ[i] = CNT_W'(i) < count_r;

    skvt_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ[i]),
      .cmp_key     (in_entry_key[EW-1:0]),
      .cmp_value   (in_entry_value[EW-1:0]),
      .ins_key     (key_r),
      .ins_value   (value_r),
      .left_lt     (left_lt),
      .left_key    (left_key),
      .left_value  (left_value),
      .right_key   (right_key),
      .right_value (right_value),
      .seen_in     (seen_in[i]),
      .key_o       (cell_key[i]),
      .value_o     (cell_value[i]),
      .lt_o        (lt[i]),
      .match_o     (match[i]),
      .seen_o      (seen[i])
    );
  end

  always_comb begin
    first_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (seen[i] && !seen_in[i]) begin
        first_key = first_key | cell_key[i];
      end
    end
  end

  assign ins_pos   = ones(lt);
  assign first_pos = ones(~seen);
  assign hits      = ones(match);
  assign found     = seen[DEPTH-1];
  assign full      = count_r == CNT_W'(DEPTH);
  assign empty     = count_r == '0;

  always_comb begin
    state_nxt           = state_r;
    count_nxt           = count_r;
    ctl                 = '0;
    ctl.cmp_en          = accept;
    out_valid_nxt       = out_valid_r && out_stall;
    out_status_nxt      = out_status_r;
    out_found_nxt       = out_found_r;
    out_position_nxt    = out_position_r;
    out_found_key_nxt   = out_found_key_r;
    out_match_count_nxt = out_match_count_r;
    out_occupancy_nxt   = out_occupancy_r;

    unique case (state_r)
      SKVT_IDLE: begin
        if (accept) begin
          state_nxt = SKVT_APPLY;
        end
      end
      SKVT_APPLY: begin
        state_nxt           = SKVT_IDLE;
        out_valid_nxt       = 1'b1;
        out_status_nxt      = STATUS_DONE;
        out_found_nxt       = 1'b0;
        out_position_nxt    = '0;
        out_found_key_nxt   = '0;
        out_match_count_nxt = '0;
        unique case (req_r)
          REQ_INSERT: begin
            if (full) begin
              out_status_nxt = STATUS_FULL;
            end else begin
              ctl.ins_en       = 1'b1;
              count_nxt        = count_r + CNT_W'(1);
              out_position_nxt = POS_W'(ins_pos);
            end
          end
          REQ_REMOVE, REQ_LOOKUP: begin
            if (empty) begin
              out_status_nxt = STATUS_EMPTY;
            end else if (!found) begin
              out_status_nxt = STATUS_NOT_FOUND;
            end else begin
              out_found_nxt    = 1'b1;
              out_position_nxt = POS_W'(first_pos);
              if (req_r == REQ_LOOKUP) begin
                out_found_key_nxt   = FIELD_W'($signed(first_key));
                out_match_count_nxt = OCC_W'(hits);
              end else begin
                ctl.rem_en = 1'b1;
                count_nxt  = count_r - CNT_W'(1);
              end
            end
          end
          default: begin
          end
        endcase
        out_occupancy_nxt = OCC_W'(count_nxt);
      end
      default: begin
        state_nxt = SKVT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SKVT_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= req_t'(in_req_type);
      key_r   <= in_entry_key[EW-1:0];
      value_r <= in_entry_value[EW-1:0];
    end
    out_status_r      <= out_status_nxt;
    out_found_r       <= out_found_nxt;
    out_position_r    <= out_position_nxt;
    out_found_key_r   <= out_found_key_nxt;
    out_match_count_r <= out_match_count_nxt;
    out_occupancy_r   <= out_occupancy_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_position    = out_position_r;
  assign out_found_key   = $signed(out_found_key_r);
  assign out_match_count = out_match_count_r;
  assign out_occupancy   = out_occupancy_r;

endmodule

`default_nettype wire

### sv/skvt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_key_value_table_core_assert.svh"

module skvt_checker
  import skvt_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic        [1:0]         out_status,
  input wire logic                      out_found,
  input wire logic        [OCC_W-1:0]   out_match_count,
  input wire logic        [OCC_W-1:0]   out_occupancy
);

  `SKVT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result beat dropped")
  `SKVT_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "beat taken while busy")
  `SKVT_ASSERT_IMPLY(a_full_occ, out_valid && out_status == STATUS_FULL, out_occupancy == OCC_W'(DEPTH), "full status with room left")
  `SKVT_ASSERT_IMPLY(a_found_done, out_valid && out_found, out_status == STATUS_DONE, "found with error status")
  `SKVT_ASSERT_IMPLY(a_count_found, out_valid && out_match_count != '0, out_found, "match count without a hit")

endmodule

bind sorted_key_value_table_core skvt_checker u_skvt_checker (.*);

`default_nettype wire
